// ===== design/terminal_line_editor_top_defines.svh =====
// Assertion macros shared by the checker of the line editor.
`ifndef TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

	localparam int LINE_DEPTH_DEF = 256;
	localparam int CHAR_W = 8;

	// Request kinds.
	localparam logic REQ_KEY  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Keyboard codes with a meaning of their own.
	localparam logic [7:0] KEY_INTR  = 8'h03;
	localparam logic [7:0] KEY_EOF   = 8'h04;
	localparam logic [7:0] KEY_BS    = 8'h08;
	localparam logic [7:0] KEY_TAB   = 8'h09;
	localparam logic [7:0] KEY_LF    = 8'h0A;
	localparam logic [7:0] KEY_CR    = 8'h0D;
	localparam logic [7:0] KEY_KILL  = 8'h15;
	localparam logic [7:0] KEY_SPACE = 8'h20;
	localparam logic [7:0] KEY_DEL   = 8'h7F;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	// Echo kinds.
	localparam logic [2:0] ECHO_NONE = 3'd0;
	localparam logic [2:0] ECHO_CHAR = 3'd1;
	localparam logic [2:0] ECHO_BS   = 3'd2;
	localparam logic [2:0] ECHO_NL   = 3'd3;
	localparam logic [2:0] ECHO_INTR = 3'd4;

	// Read status codes.
	localparam logic [1:0] RD_NONE  = 2'd0;
	localparam logic [1:0] RD_CHAR  = 2'd1;
	localparam logic [1:0] RD_EOF   = 2'd2;
	localparam logic [1:0] RD_EMPTY = 2'd3;

	typedef struct packed {
		logic       req_type;
		logic [7:0] key_code;
	} req_t;

	typedef struct packed {
		logic [2:0] echo_kind;
		logic [7:0] echo_char;
		logic [7:0] echo_count;
		logic [1:0] read_status;
		logic [7:0] read_char;
		logic       key_refused;
	} rsp_t;

endpackage

`default_nettype wire

// ===== design/terminal_line_editor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Cooked-mode line editor: each word on req is a keystroke or a one-character
// read, and each gives exactly one word on rsp. One word is taken per clock
// unless req_stall holds it off while a stalled output fills both stages; its
// result passes through one stage that waits for the line store's registered
// read and then through one output register before it shows on rsp.
// The rate is set by the line store, a single RAM that each word touches at
// most once (a write for a stored key, a read for a returned character),
// while counters and flags live in flip-flops. The store needs no clearing
// after reset, so the block takes words from the first cycle.
module terminal_line_editor_top #(
	parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire tle_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output tle_pkg::rsp_t      rsp
);

	localparam int AW = $clog2(LINE_DEPTH);

	logic          adv;
	logic          valid_s1;
	tle_pkg::rsp_t rsp_s1;
	tle_pkg::rsp_t word_s1;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	tle_ctrl #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.rsp_s1    (rsp_s1),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	tle_ram #(
		.WIDTH(tle_pkg::CHAR_W),
		.DEPTH(LINE_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The read data stays put while the stage waits, since no new read is issued.
	always_comb begin
		word_s1 = rsp_s1;
		if (rsp_s1.read_status == tle_pkg::RD_CHAR) begin
			word_s1.read_char = mem_rdata;
		end
	end

	tle_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.word_s1   (word_s1),
		.ready     (adv),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== design/tle_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/tle_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tle_ctrl #(
	parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF,
	localparam int AW = $clog2(LINE_DEPTH),
	localparam int FW = $clog2(LINE_DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire tle_pkg::req_t req,
	output logic               req_stall,
	input  wire logic          adv,
	output logic               valid_s1,
	output tle_pkg::rsp_t      rsp_s1,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [7:0]         mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr
);

	logic [FW-1:0]   fill_q, fill_d;
	logic [FW-1:0]   rd_q, rd_d;
	logic            done_q, done_d;
	logic            eof_q, eof_d;
	logic            accept;
	logic            we, re;
	logic [7:0]      ch;
	logic [FW:0]     fill_inc;
	logic [FW-1:0]   rd_inc;
	logic [FW+7:0]   fill_ext;
	logic [7:0]      kill_count;
	tle_pkg::rsp_t   rsp_d;

	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	assign ch         = (req.key_code == tle_pkg::KEY_TAB) ? tle_pkg::KEY_SPACE : req.key_code;
	assign fill_inc   = {1'b0, fill_q} + (FW+1)'(1);
	assign rd_inc     = rd_q + FW'(1);
	assign fill_ext   = {8'd0, fill_q};
	assign kill_count = (fill_ext > (FW+8)'(255)) ? tle_pkg::COUNT_MAX : fill_ext[7:0];

	always_comb begin
		fill_d    = fill_q;
		rd_d      = rd_q;
		done_d    = done_q;
		eof_d     = eof_q;
		rsp_d     = '0;
		we        = 1'b0;
		re        = 1'b0;
		mem_waddr = fill_q[AW-1:0];
		mem_wdata = tle_pkg::KEY_LF;
		mem_raddr = rd_q[AW-1:0];
		if (req.req_type == tle_pkg::REQ_READ) begin
			if (eof_q) begin
				eof_d             = 1'b0;
				rsp_d.read_status = tle_pkg::RD_EOF;
			end else if (!done_q || rd_q >= fill_q) begin
				rsp_d.read_status = tle_pkg::RD_EMPTY;
			end else begin
				// The character itself comes back from the store's registered read, in step with rsp_s1.
				rsp_d.read_status = tle_pkg::RD_CHAR;
				re                = 1'b1;
				if (rd_inc >= fill_q) begin
					done_d = 1'b0;
					fill_d = '0;
					rd_d   = '0;
				end else begin
					rd_d = rd_inc;
				end
			end
		end else if (done_q) begin
			rsp_d.key_refused = 1'b1;
		end else begin
			case (req.key_code)
				tle_pkg::KEY_LF, tle_pkg::KEY_CR: begin
					if (fill_q < FW'(LINE_DEPTH)) begin
						we     = 1'b1;
						fill_d = fill_inc[FW-1:0];
					end
					done_d          = 1'b1;
					rsp_d.echo_kind = tle_pkg::ECHO_NL;
				end
				tle_pkg::KEY_BS, tle_pkg::KEY_DEL: begin
					if (fill_q != '0) begin
						fill_d           = fill_q - FW'(1);
						rsp_d.echo_kind  = tle_pkg::ECHO_BS;
						rsp_d.echo_count = 8'd1;
					end
				end
				tle_pkg::KEY_KILL: begin
					if (fill_q != '0) begin
						fill_d           = '0;
						rsp_d.echo_kind  = tle_pkg::ECHO_BS;
						rsp_d.echo_count = kill_count;
					end
				end
				tle_pkg::KEY_EOF: begin
					if (fill_q == '0) begin
						eof_d           = 1'b1;
						rsp_d.echo_kind = tle_pkg::ECHO_NL;
					end
				end
				tle_pkg::KEY_INTR: begin
					fill_d          = '0;
					eof_d           = 1'b1;
					rsp_d.echo_kind = tle_pkg::ECHO_INTR;
				end
				default: begin
					// One slot always stays free for the closing newline.
					if (ch >= tle_pkg::KEY_SPACE && fill_inc < (FW+1)'(LINE_DEPTH)) begin
						we              = 1'b1;
						mem_wdata       = ch;
						fill_d          = fill_inc[FW-1:0];
						rsp_d.echo_kind = tle_pkg::ECHO_CHAR;
						rsp_d.echo_char = ch;
					end
				end
			endcase
		end
	end

	assign mem_we = accept && we;
	assign mem_re = accept && re;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_q     <= '0;
			done_q   <= 1'b0;
			eof_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				fill_q   <= fill_d;
				rd_q     <= rd_d;
				done_q   <= done_d;
				eof_q    <= eof_d;
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_s1 <= rsp_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/tle_obuf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tle_obuf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_s1,
	input  wire tle_pkg::rsp_t word_s1,
	output logic               ready,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output tle_pkg::rsp_t      rsp
);

	assign ready = !rsp_valid || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (ready) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_s1) begin
			rsp <= word_s1;
		end
	end

endmodule

`default_nettype wire

// ===== design/tle_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "terminal_line_editor_top_defines.svh"

module tle_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_stall,
	input  wire tle_pkg::rsp_t rsp
);

	// A read answer never carries echo, and a refused key carries nothing else.
	`TLE_ASSERT_NOW(a_read_no_echo, rsp_valid && rsp.read_status != tle_pkg::RD_NONE, rsp.echo_kind == tle_pkg::ECHO_NONE && !rsp.key_refused, "read answer carries echo or refusal")

	`TLE_ASSERT_NOW(a_refused_quiet, rsp_valid && rsp.key_refused, rsp.echo_kind == tle_pkg::ECHO_NONE && rsp.read_status == tle_pkg::RD_NONE, "refused key carries other result")

	// Only printable bytes are echoed, and an erase always echoes at least one.
	`TLE_ASSERT_NOW(a_echo_fields, rsp_valid && (rsp.echo_kind == tle_pkg::ECHO_CHAR || rsp.echo_kind == tle_pkg::ECHO_BS), (rsp.echo_kind == tle_pkg::ECHO_CHAR) ? (rsp.echo_char >= tle_pkg::KEY_SPACE && rsp.echo_char != tle_pkg::KEY_DEL && rsp.echo_count == 8'd0) : (rsp.echo_count != 8'd0 && rsp.echo_char == 8'd0), "echo fields inconsistent")

	`TLE_ASSERT_NOW(a_read_char_zero, rsp_valid && rsp.read_status != tle_pkg::RD_CHAR, rsp.read_char == 8'd0, "read_char set without a character")

	`TLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result word changed")

endmodule

bind terminal_line_editor_top tle_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
